[design/hpt_pkg.sv]
// shared types and constants for the homogeneous point transform unit
`default_nettype none

package hpt_pkg;

   localparam int HPT_FRAC_BITS = 16;
   localparam int HPT_NUM_PAIRS = 8;
   localparam int HPT_CSR_IDX_W = 8;
   localparam int HPT_COORD_W   = 32;
   localparam int HPT_QUEUE_DEPTH = 4;

   localparam logic [63:0] HPT_PAIR_RESET [HPT_NUM_PAIRS] = '{
      64'h0000_0000_0001_0000, 64'h0, 64'h0001_0000_0000_0000, 64'h0,
      64'h0, 64'h0000_0000_0001_0000, 64'h0, 64'h0001_0000_0000_0000
   };

   typedef enum logic {
      CMD_POINT  = 1'b0,
      CMD_VECTOR = 1'b1
   } cmd_type;

   typedef struct packed {
      cmd_type            command;
      logic signed [31:0] in_x;
      logic signed [31:0] in_y;
      logic signed [31:0] in_z;
   } req_word_type;

   typedef struct packed {
      logic signed [31:0] out_x;
      logic signed [31:0] out_y;
      logic signed [31:0] out_z;
      logic               saturated;
      logic               w_zero;
   } rsp_word_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

endpackage

`default_nettype wire

[design/hpt_front.sv]
// front end: coefficient registers, products and row sums
`default_nettype none

module hpt_front
   import hpt_pkg::*;
#(
   parameter int FRAC_BITS = HPT_FRAC_BITS,
   localparam int SUM_W = 64 - FRAC_BITS + 3,
   localparam int ENT_W = 1 + 4 * SUM_W
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire req_word_type             req_word,
   input  wire logic                     csr_valid,
   input  wire logic [HPT_CSR_IDX_W-1:0] csr_index,
   input  wire logic [63:0]              csr_data,
   input  wire q_status_type             q_status,
   output logic                          q_push,
   output logic [ENT_W-1:0]              q_data
);

   logic [63:0] pair_ff [HPT_NUM_PAIRS];

   logic                      s1_valid_ff, s1_valid_in;
   logic                      s2_valid_ff, s2_valid_in;
   logic                      s1_vec_ff, s2_vec_ff;
   logic signed [63:0]        prod_ff [4][3];
   logic signed [SUM_W-1:0]   sum_ff [4];
   logic signed [SUM_W-1:0]   sum_in [4];
   logic signed [31:0]        coord [3];
   logic                      adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < HPT_NUM_PAIRS; i++) pair_ff[i] <= HPT_PAIR_RESET[i];
      end else if (csr_valid && (csr_index < HPT_CSR_IDX_W'(HPT_NUM_PAIRS))) begin
         pair_ff[csr_index[$clog2(HPT_NUM_PAIRS)-1:0]] <= csr_data;
      end
   end

   assign coord[0] = req_word.in_x;
   assign coord[1] = req_word.in_y;
   assign coord[2] = req_word.in_z;

   // whole front holds only when the last stage cannot drain into the queue
   assign adv       = !(s2_valid_ff && q_status.full);
   assign req_stall = !adv;
   assign q_push    = s2_valid_ff && !q_status.full;

   assign s1_valid_in = adv ? req_valid : s1_valid_ff;
   assign s2_valid_in = adv ? s1_valid_ff : s2_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_vec_ff <= (req_word.command == CMD_VECTOR);
         for (int r = 0; r < 4; r++) begin
            for (int k = 0; k < 3; k++) begin
               prod_ff[r][k] <= $signed(pair_ff[r*2 + k/2][(k%2)*32 +: 32]) * coord[k];
            end
         end
      end
   end

   always_comb begin
      for (int r = 0; r < 4; r++) begin
         sum_in[r] = '0;
         for (int k = 0; k < 3; k++) begin
            sum_in[r] = sum_in[r] + SUM_W'(prod_ff[r][k] >>> FRAC_BITS);
         end
         // translation only for the point command; the w row always adds its last coefficient
         if (!s1_vec_ff || r == 3) begin
            sum_in[r] = sum_in[r] + SUM_W'($signed(pair_ff[r*2 + 1][63:32]));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_vec_ff <= s1_vec_ff;
         for (int r = 0; r < 4; r++) sum_ff[r] <= sum_in[r];
      end
   end

   assign q_data = {s2_vec_ff, sum_ff[0], sum_ff[1], sum_ff[2], sum_ff[3]};

endmodule

`default_nettype wire

[design/hpt_fifo.sv]
// small queue between front and back
`default_nettype none

module hpt_fifo
   import hpt_pkg::*;
#(
   parameter int DATA_W = 8,
   parameter int DEPTH  = HPT_QUEUE_DEPTH,
   localparam int PTR_W = $clog2(DEPTH),
   localparam int CNT_W = $clog2(DEPTH + 1)
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire logic [DATA_W-1:0] push_data,
   input  wire logic              pop,
   output logic [DATA_W-1:0]      head_data,
   output q_status_type           status
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ff, wr_in, rd_ff, rd_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;

   assign status.full  = (cnt_ff == CNT_W'(DEPTH));
   assign status.empty = (cnt_ff == '0);
   assign head_data    = mem_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) wr_in = (wr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      if (pop)  rd_in = (rd_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      if (push && !pop) cnt_in = cnt_ff + 1'b1;
      if (pop && !push) cnt_in = cnt_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= push_data;
   end

`ifndef ASSERT_OFF
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !status.full) else $error("queue push while full");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !status.empty) else $error("queue pop while empty");
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (cnt_ff == $past(cnt_ff) + 1'b1))
      else $error("queue count did not follow push");
`endif

endmodule

`default_nettype wire

[design/hpt_back.sv]
// back end: perspective divide pipeline, saturation and result register
`default_nettype none

module hpt_back
   import hpt_pkg::*;
#(
   parameter int FRAC_BITS = HPT_FRAC_BITS,
   localparam int SUM_W = 64 - FRAC_BITS + 3,
   localparam int ENT_W = 1 + 4 * SUM_W,
   localparam int QW    = HPT_COORD_W + 1,
   localparam int NW    = SUM_W + FRAC_BITS,
   localparam int HW    = NW - QW,
   localparam int CW    = (HW > SUM_W) ? HW : SUM_W
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire q_status_type     q_status,
   input  wire logic [ENT_W-1:0] q_data,
   output logic                  q_pop,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output rsp_word_type          rsp_word
);

   localparam logic [QW-1:0] Q_MAX_POS = QW'(33'h0_7fff_ffff);
   localparam logic [QW-1:0] Q_MAX_NEG = QW'(33'h0_8000_0000);

   logic adv;

   // stage b0: entry taken from the queue
   logic                    b0_valid_ff, b0_vec_ff;
   logic signed [SUM_W-1:0] b0_sum_ff [4];

   // stage b1: signs and magnitudes
   logic                    b1_valid_ff, b1_div_ff, b1_wz_ff;
   logic [SUM_W-1:0]        b1_n_ff [3];
   logic [SUM_W-1:0]        b1_d_ff;
   logic                    b1_neg_ff [3];
   logic signed [SUM_W-1:0] b1_raw_ff [3];

   // divide stages 0..QW
   logic                    dv_valid_ff [QW+1];
   logic                    dv_div_ff [QW+1];
   logic                    dv_wz_ff [QW+1];
   logic [SUM_W-1:0]        dv_d_ff [QW+1];
   logic                    dv_neg_ff [QW+1][3];
   logic                    dv_ovf_ff [QW+1][3];
   logic signed [SUM_W-1:0] dv_raw_ff [QW+1][3];
   logic [SUM_W-1:0]        dv_rem_ff [QW+1][3];
   logic [QW-1:0]           dv_low_ff [QW+1][3];
   logic [QW-1:0]           dv_q_ff [QW+1][3];

   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_word_type            rsp_word_ff, rsp_word_in;

   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign q_pop     = adv && !q_status.empty;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         b0_valid_ff <= 1'b0;
         b1_valid_ff <= 1'b0;
         for (int s = 0; s <= QW; s++) dv_valid_ff[s] <= 1'b0;
      end else if (adv) begin
         b0_valid_ff    <= q_pop;
         b1_valid_ff    <= b0_valid_ff;
         dv_valid_ff[0] <= b1_valid_ff;
         for (int s = 1; s <= QW; s++) dv_valid_ff[s] <= dv_valid_ff[s-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         b0_vec_ff    <= q_data[ENT_W-1];
         b0_sum_ff[0] <= q_data[4*SUM_W-1 -: SUM_W];
         b0_sum_ff[1] <= q_data[3*SUM_W-1 -: SUM_W];
         b0_sum_ff[2] <= q_data[2*SUM_W-1 -: SUM_W];
         b0_sum_ff[3] <= q_data[SUM_W-1 -: SUM_W];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         b1_wz_ff  <= !b0_vec_ff && (b0_sum_ff[3] == '0);
         b1_div_ff <= !b0_vec_ff && (b0_sum_ff[3] != '0);
         b1_d_ff   <= b0_sum_ff[3][SUM_W-1] ? SUM_W'(-b0_sum_ff[3]) : SUM_W'(b0_sum_ff[3]);
         for (int l = 0; l < 3; l++) begin
            b1_raw_ff[l] <= b0_sum_ff[l];
            b1_n_ff[l]   <= b0_sum_ff[l][SUM_W-1] ? SUM_W'(-b0_sum_ff[l])
                                                  : SUM_W'(b0_sum_ff[l]);
            b1_neg_ff[l] <= b0_sum_ff[l][SUM_W-1] ^ b0_sum_ff[3][SUM_W-1];
         end
      end
   end

   // first divide stage: quotient overflow check and initial remainder
   always_ff @(posedge clock) begin
      logic [NW-1:0] nfull;
      logic [CW-1:0] high;
      logic          ovf;
      if (adv) begin
         dv_div_ff[0] <= b1_div_ff;
         dv_wz_ff[0]  <= b1_wz_ff;
         dv_d_ff[0]   <= b1_d_ff;
         for (int l = 0; l < 3; l++) begin
            nfull = {b1_n_ff[l], {FRAC_BITS{1'b0}}};
            high  = CW'(nfull[NW-1:QW]);
            ovf   = (high >= CW'(b1_d_ff));
            dv_ovf_ff[0][l] <= ovf;
            dv_rem_ff[0][l] <= ovf ? '0 : high[SUM_W-1:0];
            dv_low_ff[0][l] <= nfull[QW-1:0];
            dv_q_ff[0][l]   <= '0;
            dv_neg_ff[0][l] <= b1_neg_ff[l];
            dv_raw_ff[0][l] <= b1_raw_ff[l];
         end
      end
   end

   // one quotient bit per stage
   for (genvar s = 1; s <= QW; s++) begin : g_div
      always_ff @(posedge clock) begin
         logic [SUM_W:0] trial;
         logic           ge;
         if (adv) begin
            dv_div_ff[s] <= dv_div_ff[s-1];
            dv_wz_ff[s]  <= dv_wz_ff[s-1];
            dv_d_ff[s]   <= dv_d_ff[s-1];
            for (int l = 0; l < 3; l++) begin
               trial = {dv_rem_ff[s-1][l], dv_low_ff[s-1][l][QW-1]};
               ge    = (trial >= {1'b0, dv_d_ff[s-1]});
               dv_rem_ff[s][l] <= ge ? SUM_W'(trial - {1'b0, dv_d_ff[s-1]})
                                     : trial[SUM_W-1:0];
               dv_q_ff[s][l]   <= {dv_q_ff[s-1][l][QW-2:0], ge};
               dv_low_ff[s][l] <= {dv_low_ff[s-1][l][QW-2:0], 1'b0};
               dv_ovf_ff[s][l] <= dv_ovf_ff[s-1][l];
               dv_neg_ff[s][l] <= dv_neg_ff[s-1][l];
               dv_raw_ff[s][l] <= dv_raw_ff[s-1][l];
            end
         end
      end
   end

   // sign, clamp and flags
   always_comb begin
      logic [31:0]  val [3];
      logic         over [3];
      logic [QW-1:0] q;
      for (int l = 0; l < 3; l++) begin
         q = dv_q_ff[QW][l];
         if (dv_div_ff[QW]) begin
            if (dv_neg_ff[QW][l]) begin
               over[l] = dv_ovf_ff[QW][l] || (q > Q_MAX_NEG);
               val[l]  = over[l] ? 32'h8000_0000 : 32'(-q[31:0]);
            end else begin
               over[l] = dv_ovf_ff[QW][l] || (q > Q_MAX_POS);
               val[l]  = over[l] ? 32'h7fff_ffff : q[31:0];
            end
         end else begin
            if (dv_raw_ff[QW][l] > SUM_W'(signed'(32'sh7fff_ffff))) begin
               over[l] = 1'b1;
               val[l]  = 32'h7fff_ffff;
            end else if (dv_raw_ff[QW][l] < SUM_W'(signed'(-32'sh8000_0000))) begin
               over[l] = 1'b1;
               val[l]  = 32'h8000_0000;
            end else begin
               over[l] = 1'b0;
               val[l]  = dv_raw_ff[QW][l][31:0];
            end
         end
      end
      rsp_word_in.out_x     = val[0];
      rsp_word_in.out_y     = val[1];
      rsp_word_in.out_z     = val[2];
      rsp_word_in.saturated = over[0] || over[1] || over[2];
      rsp_word_in.w_zero    = dv_wz_ff[QW];
   end

   assign rsp_valid_in = adv ? dv_valid_ff[QW] : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else       rsp_valid_ff <= rsp_valid_in;
   end

   always_ff @(posedge clock) begin
      if (adv) rsp_word_ff <= rsp_word_in;
   end

endmodule

`default_nettype wire

[design/homogeneous_point_transform_unit.sv]
// top level of the 4x4 homogeneous point transform with perspective divide
//
//   channel  direction  handshake             word
//   req      in         req_valid/req_stall   req_word_type (command, in_x, in_y, in_z)
//   rsp      out        rsp_valid/rsp_stall   rsp_word_type (out_x..z, saturated, w_zero)
//   csr      in         csr_valid/csr_ready   csr_index, csr_data (coefficient pairs)
//
// one word accepted per cycle while req_stall is low, one result per cycle sustained while rsp_stall is low
// pipeline: 2 front stages, queue, 3 back stages, 33 divide stages, output
// the divide pipeline produces one quotient bit per stage for all three coordinates
// synchronous reset clears control and loads the identity matrix
// rsp_stall freezes the back pipeline; the 4-word queue lets the front keep taking words
`default_nettype none

module homogeneous_point_transform_unit
   import hpt_pkg::*;
#(
   parameter int FRAC_BITS = HPT_FRAC_BITS
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire req_word_type             req_word,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output rsp_word_type                  rsp_word,
   input  wire logic                     csr_valid,
   output logic                          csr_ready,
   input  wire logic [HPT_CSR_IDX_W-1:0] csr_index,
   input  wire logic [63:0]              csr_data
);

   // row sums carry full width, no wrap
   localparam int SUM_W = 64 - FRAC_BITS + 3;
   localparam int ENT_W = 1 + 4 * SUM_W;

   q_status_type     q_status;
   logic             q_push, q_pop;
   logic [ENT_W-1:0] q_wdata, q_rdata;

   // coefficient writes always taken
   assign csr_ready = 1'b1;

   // products, row sums, command class
   hpt_front #(.FRAC_BITS(FRAC_BITS)) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .csr_valid (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .q_status  (q_status),
      .q_push    (q_push),
      .q_data    (q_wdata)
   );

   // decouples front stalls from back stalls
   hpt_fifo #(.DATA_W(ENT_W), .DEPTH(HPT_QUEUE_DEPTH)) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_wdata),
      .pop       (q_pop),
      .head_data (q_rdata),
      .status    (q_status)
   );

   // divide by w, saturate, hold result
   hpt_back #(.FRAC_BITS(FRAC_BITS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_status  (q_status),
      .q_data    (q_rdata),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

endmodule

`default_nettype wire
